FILE: rtl/cfr_pkg.sv
`default_nettype none
package cfr_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned HEADER_BYTES = 5;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [BYTE_W-1:0] HEADER_BYTE_RESET = 8'd0;
  localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET  = 8'd248;

  localparam logic [BYTE_W-1:0] HEAD_CHK_POS = BYTE_W'(HEADER_BYTES - 1);
  localparam logic [BYTE_W-1:0] TYPE_POS     = 8'd1;
  localparam logic [BYTE_W-1:0] CMD_POS      = 8'd2;
  localparam logic [BYTE_W-1:0] LEN_POS      = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_BYTE = 1'b0,
    REG_MAX_LENGTH  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_HEAD = 3'd1,
    PH_DATA = 3'd2,
    PH_DCHK = 3'd3,
    PH_SKIP = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_GOOD       = 2'd1,
    KIND_HDR_REJECT = 2'd2,
    KIND_DATA_BAD   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] frm_type;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] data_length;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] max_data_length;
  } cfg_t;

  function automatic logic [BYTE_W-1:0] negate8(input logic [BYTE_W-1:0] s);
    negate8 = BYTE_W'(~s + 8'd1);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cfr_in_if.sv
`default_nettype none
interface cfr_in_if;
  logic                      valid;
  logic                      ready;
  logic [cfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/cfr_out_if.sv
`default_nettype none
interface cfr_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [cfr_pkg::BYTE_W-1:0] frm_type;
  logic [cfr_pkg::BYTE_W-1:0] command;
  logic [cfr_pkg::BYTE_W-1:0] data_length;
  logic [cfr_pkg::BYTE_W-1:0] data_byte;
  logic [cfr_pkg::BYTE_W-1:0] byte_index;

  modport source (output valid, output kind, output frm_type, output command,
                  output data_length, output data_byte, output byte_index,
                  input ready);
  modport sink   (input valid, input kind, input frm_type, input command,
                  input data_length, input data_byte, input byte_index,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/cfr_cfg_if.sv
`default_nettype none
interface cfr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cfr_pkg::CFG_IDX_W-1:0] index;
  logic [cfr_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/cfr_cfg_regs.sv
`default_nettype none
module cfr_cfg_regs (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cfr_cfg_if.sink     cfg_if,
  output cfr_pkg::cfg_t cfg
);

  logic [cfr_pkg::BYTE_W-1:0] header_byte_r, header_byte_nxt;
  logic [cfr_pkg::BYTE_W-1:0] max_len_r, max_len_nxt;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    header_byte_nxt = header_byte_r;
    max_len_nxt     = max_len_r;
    if (cfg_if.valid) begin
      unique case (cfr_pkg::cfg_reg_t'(cfg_if.index))
        cfr_pkg::REG_HEADER_BYTE: header_byte_nxt = cfg_if.data;
        cfr_pkg::REG_MAX_LENGTH:  max_len_nxt     = cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r <= cfr_pkg::HEADER_BYTE_RESET;
      max_len_r     <= cfr_pkg::MAX_LENGTH_RESET;
    end else begin
      header_byte_r <= header_byte_nxt;
      max_len_r     <= max_len_nxt;
    end
  end

  assign cfg.header_byte     = header_byte_r;
  assign cfg.max_data_length = max_len_r;

endmodule
`default_nettype wire

FILE: rtl/cfr_parser.sv
`default_nettype none
module cfr_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       take,
  input  wire logic [cfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire cfr_pkg::cfg_t              cfg,
  output logic                            res_valid,
  output cfr_pkg::result_t                res
);

  cfr_pkg::phase_t            phase_r, phase_nxt;
  logic [cfr_pkg::BYTE_W-1:0] type_r, type_nxt;
  logic [cfr_pkg::BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [cfr_pkg::BYTE_W-1:0] len_r, len_nxt;
  logic [cfr_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [cfr_pkg::BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [cfr_pkg::BYTE_W-1:0] cnt_inc;
  logic [cfr_pkg::BYTE_W-1:0] sum_add;
  cfr_pkg::kind_t             kind;
  logic [cfr_pkg::BYTE_W-1:0] dbyte;
  logic [cfr_pkg::BYTE_W-1:0] idx;

  assign cnt_inc = cfr_pkg::BYTE_W'(cnt_r + 8'd1);
  assign sum_add = cfr_pkg::BYTE_W'(sum_r + rx_byte);

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    res_valid = 1'b0;
    kind      = cfr_pkg::KIND_DATA;
    dbyte     = '0;
    idx       = '0;
    if (take) begin
      unique case (phase_r)
        cfr_pkg::PH_HEAD: begin
          if (cnt_r >= cfr_pkg::HEAD_CHK_POS) begin
            cnt_nxt = '0;
            if (rx_byte == cfr_pkg::negate8(sum_r)) begin
              sum_nxt   = rx_byte;
              phase_nxt = (len_r == '0) ? cfr_pkg::PH_DCHK : cfr_pkg::PH_DATA;
            end else begin
              phase_nxt = cfr_pkg::PH_SKIP;
              res_valid = 1'b1;
              kind      = cfr_pkg::KIND_HDR_REJECT;
            end
          end else begin
            sum_nxt = sum_add;
            cnt_nxt = cnt_inc;
            case (cnt_r)
              cfr_pkg::TYPE_POS: type_nxt = rx_byte;
              cfr_pkg::CMD_POS:  cmd_nxt  = rx_byte;
              cfr_pkg::LEN_POS: begin
                len_nxt = rx_byte;
                if (rx_byte > cfg.max_data_length) begin
                  phase_nxt = cfr_pkg::PH_HUNT;
                  cnt_nxt   = '0;
                  res_valid = 1'b1;
                  kind      = cfr_pkg::KIND_HDR_REJECT;
                end
              end
              default: ;
            endcase
          end
        end
        cfr_pkg::PH_DATA: begin
          sum_nxt   = sum_add;
          cnt_nxt   = cnt_inc;
          if (cnt_inc == len_r) phase_nxt = cfr_pkg::PH_DCHK;
          res_valid = 1'b1;
          kind      = cfr_pkg::KIND_DATA;
          dbyte     = rx_byte;
          idx       = cnt_r;
        end
        cfr_pkg::PH_DCHK: begin
          phase_nxt = cfr_pkg::PH_HUNT;
          cnt_nxt   = '0;
          res_valid = 1'b1;
          kind      = (rx_byte == cfr_pkg::negate8(sum_r)) ?
                      cfr_pkg::KIND_GOOD : cfr_pkg::KIND_DATA_BAD;
        end
        cfr_pkg::PH_SKIP: begin
          if (cnt_r == len_r) begin
            phase_nxt = cfr_pkg::PH_HUNT;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          phase_nxt = cfr_pkg::PH_HUNT;
          if (rx_byte == cfg.header_byte) begin
            sum_nxt   = rx_byte;
            cnt_nxt   = cfr_pkg::TYPE_POS;
            phase_nxt = cfr_pkg::PH_HEAD;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.kind        = kind;
    res.frm_type    = type_nxt;
    res.command     = cmd_nxt;
    res.data_length = len_nxt;
    res.data_byte   = dbyte;
    res.byte_index  = idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cfr_pkg::PH_HUNT;
      type_r  <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cfr_out_reg.sv
`default_nettype none
module cfr_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire cfr_pkg::result_t res,
  output logic                  space,
  cfr_out_if.source             out_if
);

  logic             valid_r, valid_nxt;
  cfr_pkg::result_t data_r;

  assign space = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_if.ready) valid_nxt = 1'b0;
    if (load)         valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= res;
  end

  assign out_if.valid       = valid_r;
  assign out_if.kind        = data_r.kind;
  assign out_if.frm_type    = data_r.frm_type;
  assign out_if.command     = data_r.command;
  assign out_if.data_length = data_r.data_length;
  assign out_if.data_byte   = data_r.data_byte;
  assign out_if.byte_index  = data_r.byte_index;

endmodule
`default_nettype wire

FILE: rtl/checksummed_frame_receiver.sv
// Checksummed frame receiver.
// in_if: one received byte per word (valid/ready). Frames are start byte,
//   type, command, length, header checksum, payload, data checksum.
// out_if: at most one result word per input word: a payload byte (cut-through),
//   frame good, header rejected, or data checksum bad, tagged with the frame's
//   type, command and length.
// cfg_if: register writes (index 0 start byte, 1 max payload length); always
//   ready, write only while the receiver is idle.
// Latency: a result is valid on the cycle after the input word is accepted.
// Throughput: one input word per cycle while the output register has space;
//   the parser state update is one byte-wide add and compare per cycle.
// Stall: a single output register holds the pending result. in_if.ready is
//   high while that register is empty or being drained the same cycle, so an
//   output stall backpressures the input once a result word is pending.
// Reset (rst_n, synchronous): parser returns to hunting for the start byte,
//   held fields and checksum clear, start byte reads 0, max length 248,
//   output register empty.
`default_nettype none
module checksummed_frame_receiver (
  input  wire logic clk,
  input  wire logic rst_n,
  cfr_in_if.sink    in_if,
  cfr_out_if.source out_if,
  cfr_cfg_if.sink   cfg_if
);

  cfr_pkg::cfg_t    cfg;
  cfr_pkg::result_t res;
  logic             res_valid;
  logic             space;
  logic             take;

  assign in_if.ready = space;
  assign take        = in_if.valid && space;

  cfr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  cfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_if.rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  cfr_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (take && res_valid),
    .res    (res),
    .space  (space),
    .out_if (out_if)
  );

endmodule
`default_nettype wire

FILE: test/tb_checksummed_frame_receiver.sv
`timescale 1ns / 1ps
module tb_checksummed_frame_receiver;

  localparam int HOLD_OFF    = 4;
  localparam int STALL_LIMIT = 2000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cfr_in_if  in_ch ();
  cfr_out_if out_ch ();
  cfr_cfg_if cfg_ch ();

  checksummed_frame_receiver u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  always #10 clk = ~clk;

  int send_idle_pct = 36;
  int recv_idle_pct = 47;
  int bytes_sent    = 0;
  int mismatches    = 0;
  int stall_cycles  = 0;

  // stimulus-side copy of the registers, used to build frames
  logic [7:0] tx_start = cfr_pkg::HEADER_BYTE_RESET;
  logic [7:0] tx_max   = cfr_pkg::MAX_LENGTH_RESET;

  // predictor state
  cfr_pkg::phase_t p_phase   = cfr_pkg::PH_HUNT;
  logic [7:0]      p_type    = '0;
  logic [7:0]      p_cmd     = '0;
  logic [7:0]      p_len     = '0;
  logic [7:0]      p_sum     = '0;
  logic [7:0]      p_pos     = '0;
  logic [7:0]      p_start   = cfr_pkg::HEADER_BYTE_RESET;
  logic [7:0]      p_max_len = cfr_pkg::MAX_LENGTH_RESET;

  cfr_pkg::result_t deframed_q[$];
  cfr_pkg::result_t want, got;

  function automatic void deframe_byte(input logic [7:0] b);
    cfr_pkg::result_t r;
    bit               emit;
    logic [7:0]       neg;
    r    = '0;
    emit = 1'b0;
    neg  = -p_sum;
    case (p_phase)
      cfr_pkg::PH_HEAD: begin
        if (p_pos >= cfr_pkg::HEAD_CHK_POS) begin
          p_pos = '0;
          if (b == neg) begin
            p_sum   = b;
            p_phase = (p_len == 8'd0) ? cfr_pkg::PH_DCHK : cfr_pkg::PH_DATA;
          end else begin
            p_phase = cfr_pkg::PH_SKIP;
            r.kind  = cfr_pkg::KIND_HDR_REJECT;
            emit    = 1'b1;
          end
        end else begin
          p_sum = p_sum + b;
          if (p_pos == cfr_pkg::TYPE_POS) p_type = b;
          else if (p_pos == cfr_pkg::CMD_POS) p_cmd = b;
          else if (p_pos == cfr_pkg::LEN_POS) begin
            p_len = b;
            if (b > p_max_len) begin
              p_phase = cfr_pkg::PH_HUNT;
              p_pos   = '0;
              r.kind  = cfr_pkg::KIND_HDR_REJECT;
              emit    = 1'b1;
            end
          end
          if (!emit) p_pos = p_pos + 8'd1;
        end
      end
      cfr_pkg::PH_DATA: begin
        r.kind       = cfr_pkg::KIND_DATA;
        r.data_byte  = b;
        r.byte_index = p_pos;
        emit         = 1'b1;
        p_sum        = p_sum + b;
        p_pos        = p_pos + 8'd1;
        if (p_pos == p_len) p_phase = cfr_pkg::PH_DCHK;
      end
      cfr_pkg::PH_DCHK: begin
        p_phase = cfr_pkg::PH_HUNT;
        p_pos   = '0;
        r.kind  = (b == neg) ? cfr_pkg::KIND_GOOD : cfr_pkg::KIND_DATA_BAD;
        emit    = 1'b1;
      end
      cfr_pkg::PH_SKIP: begin
        if (p_pos == p_len) begin
          p_phase = cfr_pkg::PH_HUNT;
          p_pos   = '0;
        end else begin
          p_pos = p_pos + 8'd1;
        end
      end
      default: begin
        p_phase = cfr_pkg::PH_HUNT;
        if (b == p_start) begin
          p_sum   = b;
          p_pos   = 8'd1;
          p_phase = cfr_pkg::PH_HEAD;
        end
      end
    endcase
    if (emit) begin
      r.frm_type    = p_type;
      r.command     = p_cmd;
      r.data_length = p_len;
      deframed_q.push_back(r);
    end
  endfunction

  // check first, then predict, so a stray word never meets a fresh expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == cfr_pkg::REG_HEADER_BYTE) p_start = cfg_ch.data;
        else p_max_len = cfg_ch.data;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{cfr_pkg::kind_t'(out_ch.kind), out_ch.frm_type, out_ch.command,
                out_ch.data_length, out_ch.data_byte, out_ch.byte_index};
        if (deframed_q.size() == 0) begin
          mismatches++;
          $display("%0t: expected no word, actual kind=%0d type=%02h cmd=%02h",
                   $time, got.kind, got.frm_type, got.command);
          $display("%0t:   len=%0d data=%02h idx=%0d",
                   $time, got.data_length, got.data_byte, got.byte_index);
        end else begin
          want = deframed_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: expected kind=%0d type=%02h cmd=%02h len=%0d data=%02h idx=%0d",
                     $time, want.kind, want.frm_type, want.command,
                     want.data_length, want.data_byte, want.byte_index);
            $display("%0t:   actual kind=%0d type=%02h cmd=%02h len=%0d data=%02h idx=%0d",
                     $time, got.kind, got.frm_type, got.command,
                     got.data_length, got.data_byte, got.byte_index);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.rx_byte);
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(input cfr_pkg::cfg_reg_t idx, input logic [7:0] v);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == cfr_pkg::REG_HEADER_BYTE) tx_start = v;
    else tx_max = v;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fcmd,
                            input logic [7:0] flen, input bit bad_hdr, input bit bad_data);
    logic [7:0] hchk;
    logic [7:0] dsum;
    logic [7:0] d;
    hchk = -(tx_start + ftype + fcmd + flen);
    if (bad_hdr) hchk = hchk ^ (8'd1 << $urandom_range(0, 7));
    send_byte(tx_start);
    send_byte(ftype);
    send_byte(fcmd);
    send_byte(flen);
    if (flen > tx_max) return;
    send_byte(hchk);
    if (bad_hdr) begin
      repeat (int'(flen) + 1) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    dsum = hchk;
    repeat (int'(flen)) begin
      d    = 8'($urandom_range(0, 255));
      dsum = dsum + d;
      send_byte(d);
    end
    dsum = -dsum;
    if (bad_data) dsum = dsum ^ (8'd1 << $urandom_range(0, 7));
    send_byte(dsum);
  endtask

  // reset values: start byte 0, max length 248
  task automatic test_hunt_and_defaults();
    send_byte(8'hFF);
    send_frame(8'hFF, 8'h00, 8'd0, 1'b0, 1'b0);
    send_frame(8'h00, 8'hFF, 8'd1, 1'b0, 1'b1);
    send_frame(8'h12, 8'h34, 8'd255, 1'b0, 1'b0);
    send_frame(8'hAB, 8'hCD, 8'd0, 1'b1, 1'b0);
  endtask

  task automatic test_register_extremes();
    write_reg(cfr_pkg::REG_HEADER_BYTE, 8'hFF);
    write_reg(cfr_pkg::REG_MAX_LENGTH, 8'd0);
    send_byte(8'h00);
    send_frame(8'h5A, 8'hA5, 8'd0, 1'b0, 1'b0);
    send_frame(8'h01, 8'h80, 8'd1, 1'b0, 1'b0);
  endtask

  task automatic test_traffic_phase(input int gap_pct, input int stall_pct,
                                    input logic [7:0] start_b, input logic [7:0] max_len,
                                    input int n_bytes);
    int         stop_at;
    int         pick;
    int         lim;
    logic [7:0] len;
    send_idle_pct = gap_pct;
    recv_idle_pct = stall_pct;
    write_reg(cfr_pkg::REG_HEADER_BYTE, start_b);
    write_reg(cfr_pkg::REG_MAX_LENGTH, max_len);
    stop_at = bytes_sent + n_bytes;
    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), tx_max,
               1'b0, 1'b0);
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 8) begin
        // truncated frame
        send_byte(tx_start);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        lim = (tx_max < 8'd12) ? int'(tx_max) : 12;
        if ($urandom_range(0, 39) == 0) len = 8'($urandom_range(0, tx_max));
        else len = 8'($urandom_range(0, lim));
        if ($urandom_range(0, 99) < 6 && tx_max != 8'hFF)
          len = 8'($urandom_range(int'(tx_max) + 1, 255));
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                   $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 8);
      end
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = cfr_pkg::REG_HEADER_BYTE;
    cfg_ch.data   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_hunt_and_defaults();
    test_register_extremes();
    test_traffic_phase(36, 47, 8'($urandom_range(0, 255)), 8'd248, 470);
    test_traffic_phase(47, 36, 8'($urandom_range(0, 255)), 8'($urandom_range(1, 40)), 470);
    test_traffic_phase(0, 0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 248)), 470);
    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cfr_pkg.sv
rtl/cfr_in_if.sv
rtl/cfr_out_if.sv
rtl/cfr_cfg_if.sv
rtl/cfr_cfg_regs.sv
rtl/cfr_parser.sv
rtl/cfr_out_reg.sv
rtl/checksummed_frame_receiver.sv
test/tb_checksummed_frame_receiver.sv
